[hdl/fpp_pkg.sv]
// Shared types, constants and helper functions for the framed packet parser.
package fpp_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 7;
  localparam int CFG_IDX_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_SECOND = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND = CFG_IDX_W'(3);

  localparam logic [7:0]  HEAD_FIRST_RST  = 8'd170;
  localparam logic [7:0]  HEAD_SECOND_RST = 8'd85;
  localparam logic [7:0]  TAIL_FIRST_RST  = 8'd13;
  localparam logic [7:0]  TAIL_SECOND_RST = 8'd10;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] CNT_MAX         = 16'hFFFF;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_FRAME = 2'd1,
    EV_CRC   = 2'd2,
    EV_GOOD  = 2'd3
  } event_e;

  typedef enum logic [3:0] {
    PH_HEAD1 = 4'd0,
    PH_HEAD2 = 4'd1,
    PH_VER   = 4'd2,
    PH_SRC   = 4'd3,
    PH_DST   = 4'd4,
    PH_TYPE  = 4'd5,
    PH_FUNC  = 4'd6,
    PH_SEQ   = 4'd7,
    PH_LEN   = 4'd8,
    PH_DATA  = 4'd9,
    PH_CRCLO = 4'd10,
    PH_CRCHI = 4'd11,
    PH_TAIL1 = 4'd12,
    PH_TAIL2 = 4'd13
  } parse_phase_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_RD,
    ST_EMIT
  } ctl_state_e;

  // CRC-16/MODBUS, one byte, reflected
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

[hdl/framed_packet_parser_crc16_core.sv]
// Framed packet parser with CRC-16/MODBUS check: top level.
//
// One received byte is taken per cycle while parsing, unless the output is stalled; each
// byte gives one registered result word, except the second tail byte of a good frame with
// a payload, which hands the frame to a replay of the payload memory. The memory has one
// write port and one registered read port; the replay passes a read state and an emit state
// per word, waits at emit while the output is stalled, and takes no new byte meanwhile. A
// good frame with an empty payload gives one word at once. A frame of N payload bytes is
// N + 13 bytes on the wire. The payload memory needs no clearing after reset: only entries
// written in the current frame are read. Configuration writes are always ready.
module framed_packet_parser_crc16_core
  import fpp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  // input bytes
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rx_byte_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           event_code_o,
  output logic [7:0]           version_byte_o,
  output logic [7:0]           source_address_o,
  output logic [7:0]           dest_address_o,
  output logic [7:0]           message_type_o,
  output logic [7:0]           function_code_o,
  output logic [7:0]           sequence_number_o,
  output logic [LEN_W-1:0]     payload_length_o,
  output logic [7:0]           payload_byte_o,
  output logic                 beat_last_o,
  output logic [15:0]          crc_error_total_o,
  output logic [15:0]          frame_error_total_o
);

  // configuration registers
  logic [7:0] head1_q, head2_q, tail1_q, tail2_q;

  // control state
  ctl_state_e   ctl_q, ctl_d;
  parse_phase_e phase_q, phase_d;
  logic [15:0]  crc_q, crc_d;
  logic [15:0]  crc_cnt_q, crc_cnt_d;
  logic [15:0]  frm_cnt_q, frm_cnt_d;
  logic [LEN_W-1:0] pay_cnt_q, pay_cnt_d;
  logic [LEN_W-1:0] rd_cnt_q, rd_cnt_d;
  logic         out_valid_q, out_valid_d;

  // header store
  logic [7:0]       hdr_q [6];
  logic [LEN_W-1:0] len_q;
  logic             hdr_we;
  logic [2:0]       hdr_idx;
  logic             len_we;

  // payload memory
  logic [7:0]        pay_mem [MAX_PAYLOAD];
  logic [7:0]        rd_data_q;
  logic              mem_we;
  logic [PAY_AW-1:0] mem_addr;

  // output word
  logic [1:0]       ev_q, ev_d;
  logic [7:0]       ohdr_q [6];
  logic [7:0]       ohdr_d [6];
  logic [LEN_W-1:0] olen_q, olen_d;
  logic [7:0]       opay_q, opay_d;
  logic             olast_q, olast_d;

  logic             in_acc, out_free, load;
  logic [LEN_W-1:0] pay_cnt_inc, rd_cnt_inc;
  logic             good_word;
  event_e           ev;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (ctl_q != ST_RUN) || !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign pay_cnt_inc = pay_cnt_q + LEN_W'(1);
  assign rd_cnt_inc  = rd_cnt_q + LEN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head1_q <= HEAD_FIRST_RST;
      head2_q <= HEAD_SECOND_RST;
      tail1_q <= TAIL_FIRST_RST;
      tail2_q <= TAIL_SECOND_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HEAD_FIRST:  head1_q <= cfg_data_i;
        REG_HEAD_SECOND: head2_q <= cfg_data_i;
        REG_TAIL_FIRST:  tail1_q <= cfg_data_i;
        REG_TAIL_SECOND: tail2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl_d       = ctl_q;
    phase_d     = phase_q;
    crc_d       = crc_q;
    crc_cnt_d   = crc_cnt_q;
    frm_cnt_d   = frm_cnt_q;
    pay_cnt_d   = pay_cnt_q;
    rd_cnt_d    = rd_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    hdr_we      = 1'b0;
    hdr_idx     = 3'(phase_q - PH_VER);
    len_we      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = pay_cnt_q[PAY_AW-1:0];
    load        = 1'b0;
    good_word   = 1'b0;
    ev          = EV_NONE;
    ev_d        = ev_q;
    ohdr_d      = ohdr_q;
    olen_d      = olen_q;
    opay_d      = opay_q;
    olast_d     = olast_q;

    case (ctl_q)
      ST_RUN: begin
        if (in_acc) begin
          load = 1'b1;
          case (phase_q)
            PH_HEAD1: begin
              if (rx_byte_i == head1_q) begin
                crc_d   = crc16_feed(CRC_INIT, rx_byte_i);
                phase_d = PH_HEAD2;
              end
            end
            PH_HEAD2: begin
              if (rx_byte_i == head2_q) begin
                crc_d     = crc16_feed(crc_q, rx_byte_i);
                pay_cnt_d = '0;
                phase_d   = PH_VER;
              end else begin
                frm_cnt_d = sat_inc(frm_cnt_q);
                ev        = EV_FRAME;
                phase_d   = PH_HEAD1;
              end
            end
            PH_VER, PH_SRC, PH_DST, PH_TYPE, PH_FUNC, PH_SEQ: begin
              hdr_we  = 1'b1;
              crc_d   = crc16_feed(crc_q, rx_byte_i);
              phase_d = parse_phase_e'(phase_q + 4'd1);
            end
            PH_LEN: begin
              if (rx_byte_i > 8'(MAX_PAYLOAD)) begin
                frm_cnt_d = sat_inc(frm_cnt_q);
                ev        = EV_FRAME;
                phase_d   = PH_HEAD1;
              end else begin
                len_we    = 1'b1;
                crc_d     = crc16_feed(crc_q, rx_byte_i);
                pay_cnt_d = '0;
                phase_d   = (rx_byte_i == 8'd0) ? PH_CRCLO : PH_DATA;
              end
            end
            PH_DATA: begin
              mem_we    = 1'b1;
              pay_cnt_d = pay_cnt_inc;
              crc_d     = crc16_feed(crc_q, rx_byte_i);
              if (pay_cnt_inc >= len_q) phase_d = PH_CRCLO;
            end
            PH_CRCLO: begin
              crc_d   = crc16_feed(crc_q, rx_byte_i);
              phase_d = PH_CRCHI;
            end
            PH_CRCHI: begin
              crc_d   = crc16_feed(crc_q, rx_byte_i);
              phase_d = PH_TAIL1;
            end
            PH_TAIL1: begin
              if (rx_byte_i == tail1_q) begin
                phase_d = PH_TAIL2;
              end else begin
                frm_cnt_d = sat_inc(frm_cnt_q);
                ev        = EV_FRAME;
                phase_d   = PH_HEAD1;
              end
            end
            PH_TAIL2: begin
              phase_d = PH_HEAD1;
              if (rx_byte_i != tail2_q) begin
                frm_cnt_d = sat_inc(frm_cnt_q);
                ev        = EV_FRAME;
              end else if (crc_q != 16'd0) begin
                crc_cnt_d = sat_inc(crc_cnt_q);
                ev        = EV_CRC;
              end else if (len_q == '0) begin
                good_word = 1'b1;
              end else begin
                // hand off to payload replay
                load     = 1'b0;
                rd_cnt_d = '0;
                ctl_d    = ST_RD;
              end
            end
            default: phase_d = PH_HEAD1;
          endcase

          if (load) begin
            out_valid_d = 1'b1;
            olast_d     = 1'b1;
            opay_d      = 8'd0;
            if (good_word) begin
              ev_d   = EV_GOOD;
              ohdr_d = hdr_q;
              olen_d = len_q;
            end else begin
              ev_d = ev;
              for (int i = 0; i < 6; i++) ohdr_d[i] = 8'd0;
              olen_d = '0;
            end
          end
        end
      end
      ST_RD: ctl_d = ST_EMIT;   // read data lands next cycle
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ev_d        = EV_GOOD;
          ohdr_d      = hdr_q;
          olen_d      = len_q;
          opay_d      = rd_data_q;
          olast_d     = (rd_cnt_inc == len_q);
          rd_cnt_d    = rd_cnt_inc;
          ctl_d       = (rd_cnt_inc == len_q) ? ST_RUN : ST_RD;
        end
      end
      default: ctl_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= ST_RUN;
      phase_q     <= PH_HEAD1;
      crc_q       <= CRC_INIT;
      crc_cnt_q   <= '0;
      frm_cnt_q   <= '0;
      pay_cnt_q   <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      len_q       <= '0;
      for (int i = 0; i < 6; i++) hdr_q[i] <= 8'd0;
    end else begin
      ctl_q       <= ctl_d;
      phase_q     <= phase_d;
      crc_q       <= crc_d;
      crc_cnt_q   <= crc_cnt_d;
      frm_cnt_q   <= frm_cnt_d;
      pay_cnt_q   <= pay_cnt_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
      if (len_we) len_q <= rx_byte_i[LEN_W-1:0];
      if (hdr_we) hdr_q[hdr_idx] <= rx_byte_i;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    ev_q    <= ev_d;
    ohdr_q  <= ohdr_d;
    olen_q  <= olen_d;
    opay_q  <= opay_d;
    olast_q <= olast_d;
  end

  // payload memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) pay_mem[mem_addr] <= rx_byte_i;
    rd_data_q <= pay_mem[rd_cnt_q[PAY_AW-1:0]];
  end

  assign out_valid_o       = out_valid_q;
  assign event_code_o      = ev_q;
  assign version_byte_o    = ohdr_q[0];
  assign source_address_o  = ohdr_q[1];
  assign dest_address_o    = ohdr_q[2];
  assign message_type_o    = ohdr_q[3];
  assign function_code_o   = ohdr_q[4];
  assign sequence_number_o = ohdr_q[5];
  assign payload_length_o  = olen_q;
  assign payload_byte_o    = opay_q;
  assign beat_last_o       = olast_q;
  // counters only move when a new word is loaded, so they match the word on display
  assign crc_error_total_o   = crc_cnt_q;
  assign frame_error_total_o = frm_cnt_q;

  a_replay_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == ST_EMIT) |-> (phase_q == PH_HEAD1))
    else $error("payload replay while a frame is being parsed");

  a_non_good_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_code_o != EV_GOOD)) |->
      (beat_last_o && (payload_byte_o == 8'd0) && (payload_length_o == '0)))
    else $error("non-good word carries frame fields");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (pay_cnt_q < len_q))
    else $error("payload write beyond frame length");

  a_replay_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == ST_RD) |-> (rd_cnt_q < len_q))
    else $error("payload replay beyond frame length");

  a_crc_cnt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (crc_cnt_q >= $past(crc_cnt_q)))
    else $error("crc fault count went down");

endmodule
